// ----- rtl/ucr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ucr_pkg;

  localparam int unsigned MAX_ROW_DEF = 16;
  localparam int unsigned DATA_W_DEF  = 32;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned RUN_W       = 32;
  localparam int unsigned POS_W       = 4;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned CFG_DATA_W  = 5;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CMD_DEPTH   = 2;
  localparam int unsigned OUT_DEPTH   = 4;

  typedef enum logic [1:0] {
    KIND_ELEM  = 2'd0,
    KIND_RUN   = 2'd1,
    KIND_COUNT = 2'd2,
    KIND_END   = 2'd3
  } kind_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROW_LENGTH   = 2'd0,
    REG_WANT_INVERSE = 2'd1,
    REG_WANT_COUNTS  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic [VALUE_W-1:0] payload;
    logic [POS_W-1:0]   position;
    logic [RUN_W-1:0]   run;
    logic               is_last;
  } result_t;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] row_length;
    logic                  want_inverse;
    logic                  want_counts;
  } cfg_t;

  typedef struct packed {
    logic               pre;
    logic [RUN_W-1:0]   pre_count;
    logic [RUN_W-1:0]   pre_run;
    logic               elems;
    logic [LEN_W-1:0]   elem_n;
    logic               tag;
    logic               inv;
    logic               fin;
    kind_t              fin_kind;
    logic [VALUE_W-1:0] fin_payload;
    logic [RUN_W-1:0]   run;
  } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/unique_consecutive_rows.sv -----
// Elements: each is taken and stored, then compared with the stored row before the next is accepted.
// A finished row goes to the emitter through a two-entry command queue; intake holds while
// two commands are outstanding. Emitter: takes a command, then for each kept element reads the
// row buffer and then transfers it; a count, run id or end item is transferred directly.
// Synchronous active-high rst clears stream state, queues and registers (row_length 1, flags 0),
// not row buffers.
`timescale 1ns / 1ps
`default_nettype none

module unique_consecutive_rows #(
  parameter int unsigned MAX_ROW = ucr_pkg::MAX_ROW_DEF,
  parameter int unsigned DATA_W  = ucr_pkg::DATA_W_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  ucr_pkg::in_item_t                 item,
  output logic                              empty,
  input  logic                              pop,
  output ucr_pkg::result_t                  result,
  input  logic                              cfg_write,
  input  logic [ucr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ucr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned CW  = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
  localparam int unsigned SW  = (DATA_W < ucr_pkg::VALUE_W) ? DATA_W : ucr_pkg::VALUE_W;
  localparam int unsigned CDW = ucr_pkg::CFG_DATA_W;

  ucr_pkg::cfg_t    cfg;
  ucr_pkg::cmd_t    cmd_in;
  ucr_pkg::cmd_t    cmd_out;
  ucr_pkg::result_t out_item;
  logic             cmd_push;
  logic             cmd_full;
  logic             cmd_pop;
  logic             cmd_empty;
  logic             done;
  logic [CW-1:0]    rd_col;
  logic             rd_tag;
  logic [SW-1:0]    rd_data;
  logic             out_push;
  logic             out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.row_length   <= CDW'(1);
      cfg.want_inverse <= 1'b0;
      cfg.want_counts  <= 1'b0;
    end else if (cfg_write) begin
      unique case (ucr_pkg::reg_index_t'(cfg_index))
        ucr_pkg::REG_ROW_LENGTH:   cfg.row_length   <= cfg_data;
        ucr_pkg::REG_WANT_INVERSE: cfg.want_inverse <= cfg_data[0];
        ucr_pkg::REG_WANT_COUNTS:  cfg.want_counts  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ucr_front #(
    .MAX_ROW (MAX_ROW),
    .DATA_W  (DATA_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .push     (push),
    .full     (full),
    .item     (item),
    .cmd_push (cmd_push),
    .cmd      (cmd_in),
    .cmd_full (cmd_full),
    .done     (done),
    .rd_col   (rd_col),
    .rd_tag   (rd_tag),
    .rd_data  (rd_data)
  );

  ucr_fifo #(
    .W     ($bits(ucr_pkg::cmd_t)),
    .DEPTH (ucr_pkg::CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .full  (cmd_full),
    .wdata (cmd_in),
    .pop   (cmd_pop),
    .empty (cmd_empty),
    .rdata (cmd_out)
  );

  ucr_back #(
    .MAX_ROW (MAX_ROW),
    .DATA_W  (DATA_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd_out),
    .rd_col    (rd_col),
    .rd_tag    (rd_tag),
    .rd_data   (rd_data),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_item  (out_item),
    .done      (done)
  );

  ucr_fifo #(
    .W     ($bits(ucr_pkg::result_t)),
    .DEPTH (ucr_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .full  (out_full),
    .wdata (out_item),
    .pop   (pop),
    .empty (empty),
    .rdata (result)
  );

endmodule

`default_nettype wire

// ----- rtl/ucr_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ucr_fifo #(
  parameter int unsigned W     = 1,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned NW   = $clog2(DEPTH + 1)
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] rdata
);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [NW-1:0] count;
  logic          do_push;
  logic          do_pop;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    wrap_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = (count == NW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wrap_inc(wptr);
      if (do_pop) rptr <= wrap_inc(rptr);
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= wdata;
  end

endmodule

`default_nettype wire

// ----- rtl/ucr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ucr_front #(
  parameter int unsigned MAX_ROW = ucr_pkg::MAX_ROW_DEF,
  parameter int unsigned DATA_W  = ucr_pkg::DATA_W_DEF,
  localparam int unsigned CW     = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1,
  localparam int unsigned SW     = (DATA_W < ucr_pkg::VALUE_W) ? DATA_W : ucr_pkg::VALUE_W
) (
  input  logic              clk,
  input  logic              rst,
  input  ucr_pkg::cfg_t     cfg,
  input  logic              push,
  output logic              full,
  input  ucr_pkg::in_item_t item,
  output logic              cmd_push,
  output ucr_pkg::cmd_t     cmd,
  input  logic              cmd_full,
  input  logic              done,
  input  logic [CW-1:0]     rd_col,
  input  logic              rd_tag,
  output logic [SW-1:0]     rd_data
);

  localparam int unsigned LW = ucr_pkg::LEN_W;
  localparam int unsigned RW = ucr_pkg::RUN_W;
  localparam int unsigned VW = ucr_pkg::VALUE_W;

  typedef enum logic {
    S_IDLE,
    S_CHECK
  } state_t;

  state_t            state;
  logic [CW-1:0]     column;
  logic              row_differs;
  logic              have_previous;
  logic              tag;
  logic [RW-1:0]     run_id;
  logic [RW-1:0]     run_length;
  logic [MAX_ROW-1:0] ps;
  logic [MAX_ROW-1:0] wr;
  logic [MAX_ROW-1:0] snap [2];
  logic [1:0]        inflight;
  logic [SW-1:0]     mem [2][MAX_ROW];
  logic [SW-1:0]     value_q;
  logic [SW-1:0]     prev_q;
  logic              last_q;

  logic              accept;
  logic [LW-1:0]     eff_len;
  logic [LW-1:0]     cnt;
  logic              differs;
  logic              complete;
  logic              new_run;
  logic              run_up;
  logic [RW-1:0]     run_next;
  logic [RW-1:0]     len_next;

  function automatic logic [RW-1:0] sat_inc(input logic [RW-1:0] x);
    sat_inc = (x == '1) ? x : x + 1'b1;
  endfunction

  assign full     = (state != S_IDLE) || (inflight >= 2'd2);
  assign accept   = push && !full;
  assign cnt      = LW'(column) + LW'(1);
  assign differs  = row_differs || (have_previous && (prev_q != value_q));
  assign complete = (cnt >= eff_len);
  assign new_run  = !have_previous || differs;
  assign run_up   = new_run && have_previous;
  assign run_next = run_up ? sat_inc(run_id) : run_id;
  assign len_next = new_run ? RW'(1) : sat_inc(run_length);
  assign cmd_push = (state == S_CHECK) && (complete || last_q);

  always_comb begin
    priority if (cfg.row_length == '0) begin
      eff_len = LW'(1);
    end else if (LW'(cfg.row_length) > LW'(MAX_ROW)) begin
      eff_len = LW'(MAX_ROW);
    end else begin
      eff_len = LW'(cfg.row_length);
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.pre_count = run_length;
    cmd.pre_run   = run_id;
    if (complete) begin
      cmd.pre         = run_up && cfg.want_counts;
      cmd.elems       = new_run;
      cmd.elem_n      = cnt;
      cmd.tag         = tag;
      cmd.inv         = cfg.want_inverse;
      cmd.fin         = last_q;
      cmd.fin_kind    = cfg.want_counts ? ucr_pkg::KIND_COUNT : ucr_pkg::KIND_END;
      cmd.fin_payload = cfg.want_counts ? len_next : '0;
      cmd.run         = run_next;
    end else begin
      cmd.pre         = cfg.want_counts && have_previous;
      cmd.fin         = 1'b1;
      cmd.fin_kind    = ucr_pkg::KIND_END;
      cmd.fin_payload = VW'(1);
      cmd.run         = run_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      column        <= '0;
      row_differs   <= 1'b0;
      have_previous <= 1'b0;
      run_id        <= '0;
      run_length    <= '0;
      ps            <= '0;
      wr            <= '0;
      tag           <= 1'b0;
      inflight      <= '0;
    end else begin
      unique case ({cmd_push, done})
        2'b10:   inflight <= inflight + 1'b1;
        2'b01:   inflight <= inflight - 1'b1;
        default: inflight <= inflight;
      endcase
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            wr[column] <= 1'b1;
            state      <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= S_IDLE;
          priority if (complete) begin
            ps          <= ps ^ wr;
            wr          <= '0;
            tag         <= ~tag;
            column      <= '0;
            row_differs <= 1'b0;
            if (last_q) begin
              have_previous <= 1'b0;
              run_id        <= '0;
              run_length    <= '0;
            end else begin
              have_previous <= 1'b1;
              run_id        <= run_next;
              run_length    <= len_next;
            end
          end else if (last_q) begin
            column        <= '0;
            row_differs   <= 1'b0;
            have_previous <= 1'b0;
            run_id        <= '0;
            run_length    <= '0;
          end else begin
            column      <= cnt[CW-1:0];
            row_differs <= differs;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_q                  <= item.value[SW-1:0];
      last_q                   <= item.last;
      mem[~ps[column]][column] <= item.value[SW-1:0];
      prev_q                   <= mem[ps[column]][column];
    end
    if ((state == S_CHECK) && complete) snap[tag] <= ps ^ wr;
    rd_data <= mem[snap[rd_tag][rd_col]][rd_col];
  end

  a_inflight_max: assert property (@(posedge clk) disable iff (rst)
    inflight <= 2'd2)
    else $error("front: more than two rows outstanding");

  a_cmd_room: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> !cmd_full)
    else $error("front: command transfer into a full queue");

  a_accept_spacing: assert property (@(posedge clk) disable iff (rst)
    accept |=> !accept)
    else $error("front: element taken during compare");

endmodule

`default_nettype wire

// ----- rtl/ucr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ucr_back #(
  parameter int unsigned MAX_ROW = ucr_pkg::MAX_ROW_DEF,
  parameter int unsigned DATA_W  = ucr_pkg::DATA_W_DEF,
  localparam int unsigned CW     = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1,
  localparam int unsigned SW     = (DATA_W < ucr_pkg::VALUE_W) ? DATA_W : ucr_pkg::VALUE_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_empty,
  output logic             cmd_pop,
  input  ucr_pkg::cmd_t    cmd,
  output logic [CW-1:0]    rd_col,
  output logic             rd_tag,
  input  logic [SW-1:0]    rd_data,
  input  logic             out_full,
  output logic             out_push,
  output ucr_pkg::result_t out_item,
  output logic             done
);

  localparam int unsigned LW = ucr_pkg::LEN_W;
  localparam int unsigned VW = ucr_pkg::VALUE_W;
  localparam int unsigned PW = ucr_pkg::POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE,
    S_ELEM,
    S_INV,
    S_FIN
  } state_t;

  state_t        state;
  ucr_pkg::cmd_t c;
  logic [LW-1:0] e;
  logic          pending;
  logic [LW-1:0] e_inc;
  logic          last_elem;
  state_t        first;
  state_t        nxt;

  function automatic state_t step_after(input state_t s, input ucr_pkg::cmd_t k);
    state_t r;
    unique case (s)
      S_IDLE:  r = k.pre ? S_PRE : k.elems ? S_ELEM : k.inv ? S_INV : k.fin ? S_FIN : S_IDLE;
      S_PRE:   r = k.elems ? S_ELEM : k.inv ? S_INV : k.fin ? S_FIN : S_IDLE;
      S_ELEM:  r = k.inv ? S_INV : k.fin ? S_FIN : S_IDLE;
      S_INV:   r = k.fin ? S_FIN : S_IDLE;
      default: r = S_IDLE;
    endcase
    step_after = r;
  endfunction

  assign first     = step_after(S_IDLE, cmd);
  assign nxt       = step_after(state, c);
  assign e_inc     = e + LW'(1);
  assign last_elem = (e_inc == c.elem_n);
  assign rd_col    = e[CW-1:0];
  assign rd_tag    = c.tag;
  assign cmd_pop   = (state == S_IDLE) && !cmd_empty;

  always_comb begin
    out_push = 1'b0;
    out_item = '0;
    unique case (state)
      S_PRE: begin
        out_push         = !out_full;
        out_item.kind    = ucr_pkg::KIND_COUNT;
        out_item.payload = c.pre_count;
        out_item.run     = c.pre_run;
      end
      S_ELEM: begin
        out_push          = pending && !out_full;
        out_item.kind     = ucr_pkg::KIND_ELEM;
        out_item.payload  = VW'(rd_data);
        out_item.position = e[PW-1:0];
        out_item.run      = c.run;
      end
      S_INV: begin
        out_push      = !out_full;
        out_item.kind = ucr_pkg::KIND_RUN;
        out_item.run  = c.run;
      end
      S_FIN: begin
        out_push         = !out_full;
        out_item.kind    = c.fin_kind;
        out_item.payload = c.fin_payload;
        out_item.run     = c.run;
        out_item.is_last = 1'b1;
      end
      default: begin
        out_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      e       <= '0;
      pending <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (!cmd_empty) begin
            c       <= cmd;
            e       <= '0;
            pending <= 1'b0;
            state   <= first;
            done    <= (first == S_IDLE);
          end
        end
        S_PRE, S_INV, S_FIN: begin
          if (!out_full) begin
            state <= nxt;
            done  <= (nxt == S_IDLE);
          end
        end
        S_ELEM: begin
          if (!pending) begin
            pending <= 1'b1;
          end else if (!out_full) begin
            pending <= 1'b0;
            if (last_elem) begin
              state <= nxt;
              done  <= (nxt == S_IDLE);
            end else begin
              e <= e_inc;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_IDLE))
    else $error("back: command retired outside idle");

  a_elem_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ELEM) |-> (e < c.elem_n))
    else $error("back: element index past row end");

endmodule

`default_nettype wire

// ----- tb/sv/unique_consecutive_rows_tb.sv -----
`timescale 1ns / 1ps

module unique_consecutive_rows_tb;
  import ucr_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned RANDOM_ITEMS = 150;
  localparam int unsigned CALM_AFTER = 120;

  typedef enum logic {
    STEP_CFG  = 1'b0,
    STEP_ITEM = 1'b1
  } step_kind_t;

  typedef struct packed {
    step_kind_t kind;
    cfg_t       cfg;
    in_item_t   it;
    logic [1:0] n_typed;
    result_t    t0;
    result_t    t1;
  } dir_row_t;

  logic clk;
  logic rst;
  logic push;
  logic full;
  in_item_t item;
  logic empty;
  logic pop;
  result_t result;
  logic cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  unique_consecutive_rows dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .result(result),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor copy of the block
  logic [CFG_DATA_W-1:0] cfg_len;
  logic cfg_inv;
  logic cfg_cnt;
  logic [VALUE_W-1:0] cur_row [MAX_ROW_DEF];
  logic [VALUE_W-1:0] prev_row [MAX_ROW_DEF];
  int unsigned col;
  bit differs;
  bit have_prev;
  logic [RUN_W-1:0] run_no;
  logic [RUN_W-1:0] run_len;

  result_t fresh[$];
  result_t collapsed_q[$];

  int unsigned mismatches;
  int unsigned cycles;
  int unsigned total_items;
  bit calm;
  bit hold_req;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic result_t mk(kind_t k, logic [VALUE_W-1:0] p, logic [POS_W-1:0] pos,
                                 logic [RUN_W-1:0] r, logic l);
    result_t x;
    x.kind = k;
    x.payload = p;
    x.position = pos;
    x.run = r;
    x.is_last = l;
    return x;
  endfunction

  function automatic int unsigned eff_len(logic [CFG_DATA_W-1:0] n);
    if (n == 0) return 1;
    if (n > MAX_ROW_DEF) return MAX_ROW_DEF;
    return n;
  endfunction

  function automatic void clear_stream();
    col = 0;
    differs = 0;
    have_prev = 0;
    run_no = '0;
    run_len = '0;
  endfunction

  function automatic void collapse_element(in_item_t it);
    int unsigned len;
    len = eff_len(cfg_len);
    if (col >= MAX_ROW_DEF) col = 0;
    cur_row[col] = it.value;
    if (have_prev && prev_row[col] != it.value) differs = 1;
    col++;
    if (col >= len) begin
      if (!have_prev || differs) begin
        if (have_prev) begin
          if (cfg_cnt) fresh.push_back(mk(KIND_COUNT, run_len, '0, run_no, 1'b0));
          if (run_no != '1) run_no++;
        end
        run_len = 1;
        for (int unsigned c = 0; c < col && c < MAX_ROW_DEF; c++)
          fresh.push_back(mk(KIND_ELEM, cur_row[c], c[POS_W-1:0], run_no, 1'b0));
      end else if (run_len != '1) begin
        run_len++;
      end
      if (cfg_inv) fresh.push_back(mk(KIND_RUN, '0, '0, run_no, 1'b0));
      prev_row = cur_row;
      have_prev = 1;
      col = 0;
      differs = 0;
      if (it.last) begin
        if (cfg_cnt) fresh.push_back(mk(KIND_COUNT, run_len, '0, run_no, 1'b1));
        else fresh.push_back(mk(KIND_END, '0, '0, run_no, 1'b1));
        clear_stream();
      end
    end else if (it.last) begin
      if (cfg_cnt && have_prev) fresh.push_back(mk(KIND_COUNT, run_len, '0, run_no, 1'b0));
      fresh.push_back(mk(KIND_END, 32'd1, '0, run_no, 1'b1));
      clear_stream();
    end
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (collapsed_q.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending: kind %0d payload %h",
                                got.kind, got.payload));
    end else begin
      want = collapsed_q.pop_front();
      if (got.kind !== want.kind)
        report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.payload !== want.payload)
        report_mismatch($sformatf("payload %h, want %h", got.payload, want.payload));
      if (got.position !== want.position)
        report_mismatch($sformatf("position %0d, want %0d", got.position, want.position));
      if (got.run !== want.run)
        report_mismatch($sformatf("run %0d, want %0d", got.run, want.run));
      if (got.is_last !== want.is_last)
        report_mismatch($sformatf("is_last %0b, want %0b", got.is_last, want.is_last));
    end
  endtask

  // receiver: random pop bursts, plus one long hold on request
  initial begin
    int unsigned gap;
    int unsigned hold;
    gap = 0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && pop && !empty) check_result(result);
      if (hold_req) begin
        hold = LONG_HOLD;
        hold_req = 0;
      end
      if (hold != 0) begin
        hold--;
        pop <= 1'b0;
      end else if (gap != 0) begin
        gap--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        gap = $urandom_range(0, 4);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic send_item(in_item_t it, int unsigned n_typed, result_t t0, result_t t1);
    if (!calm && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    fresh.delete();
    collapse_element(it);
    if (n_typed == 0) begin
      foreach (fresh[i]) collapsed_q.push_back(fresh[i]);
    end else begin
      collapsed_q.push_back(t0);
      if (n_typed > 1) collapsed_q.push_back(t1);
    end
  endtask

  // hold intake until every result is out and the block has gone quiet
  task automatic settle();
    push <= 1'b0;
    while (collapsed_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(logic [CFG_DATA_W-1:0] len, logic inv, logic cnt);
    cfg_write <= 1'b1;
    cfg_index <= REG_ROW_LENGTH;
    cfg_data <= len;
    @(posedge clk);
    cfg_len = len;
    cfg_index <= REG_WANT_INVERSE;
    cfg_data <= {{(CFG_DATA_W-1){1'b0}}, inv};
    @(posedge clk);
    cfg_inv = inv;
    cfg_index <= REG_WANT_COUNTS;
    cfg_data <= {{(CFG_DATA_W-1){1'b0}}, cnt};
    @(posedge clk);
    cfg_cnt = cnt;
    cfg_write <= 1'b0;
  endtask

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2, 3: return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic dir_row_t cfg_step(logic [CFG_DATA_W-1:0] len, logic inv, logic cnt);
    dir_row_t s;
    s = '0;
    s.kind = STEP_CFG;
    s.cfg.row_length = len;
    s.cfg.want_inverse = inv;
    s.cfg.want_counts = cnt;
    return s;
  endfunction

  function automatic dir_row_t item_step(logic [VALUE_W-1:0] v, logic l, logic [1:0] n,
                                         result_t a, result_t b);
    dir_row_t s;
    s = '0;
    s.kind = STEP_ITEM;
    s.it.value = v;
    s.it.last = l;
    s.n_typed = n;
    s.t0 = a;
    s.t1 = b;
    return s;
  endfunction

  // one configuration, then rows that mostly repeat or change a little
  task automatic run_phase(int unsigned budget, bit squeeze);
    logic [VALUE_W-1:0] row_vals [MAX_ROW_DEF];
    logic [CFG_DATA_W-1:0] len_cfg;
    in_item_t it;
    int unsigned len;
    int unsigned done;
    int unsigned stop;
    bit fin;
    settle();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: len_cfg = $urandom_range(1, 3);
      6, 7: len_cfg = $urandom_range(4, 8);
      8: len_cfg = $urandom_range(9, 16);
      default: begin
        case ($urandom_range(0, 2))
          0: len_cfg = '0;
          1: len_cfg = MAX_ROW_DEF;
          default: len_cfg = $urandom_range(MAX_ROW_DEF + 1, 31);
        endcase
      end
    endcase
    // every row yields a result here, so the hold backs the block up
    if (squeeze) len_cfg = 5'd1;
    apply_config(len_cfg, squeeze || ($urandom_range(0, 1) != 0), $urandom_range(0, 1) != 0);
    if (squeeze) hold_req = 1;
    len = eff_len(len_cfg);
    for (int c = 0; c < MAX_ROW_DEF; c++) row_vals[c] = pick_value();
    done = 0;
    fin = 0;
    while (!fin) begin
      case ($urandom_range(0, 3))
        0, 1: ;
        2: row_vals[$urandom_range(0, len - 1)] = pick_value();
        default: for (int c = 0; c < len; c++) row_vals[c] = pick_value();
      endcase
      stop = len;
      if (len > 1 && $urandom_range(0, 11) == 0) stop = $urandom_range(1, len - 1);
      fin = (done + len >= budget);
      for (int unsigned c = 0; c < stop; c++) begin
        it.value = row_vals[c];
        it.last = (c == stop - 1) && (stop < len || fin || $urandom_range(0, 5) == 0);
        send_item(it, 0, '0, '0);
        done++;
        total_items++;
        if (total_items >= CALM_AFTER) calm = 1;
      end
    end
  endtask

  initial begin
    dir_row_t script[$];
    dir_row_t st;
    int unsigned phase;
    logic [VALUE_W-1:0] v;
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    pop = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_ROW_LENGTH;
    cfg_data = '0;
    mismatches = 0;
    cycles = 0;
    total_items = 0;
    calm = 0;
    hold_req = 0;
    cfg_len = 1;
    cfg_inv = 0;
    cfg_cnt = 0;
    clear_stream();

    // flat mode after reset, extremes of the value
    script.push_back(item_step('0, 1'b0, 1, mk(KIND_ELEM, '0, '0, '0, 1'b0), '0));
    script.push_back(item_step('1, 1'b1, 2, mk(KIND_ELEM, '1, '0, 32'd1, 1'b0),
                               mk(KIND_END, '0, '0, 32'd1, 1'b1)));
    // full-width row with both extras on; writes every column of the row buffers
    script.push_back(cfg_step(MAX_ROW_DEF, 1'b1, 1'b1));
    for (int c = 0; c < MAX_ROW_DEF; c++) begin
      case (c)
        0: v = '0;
        7: v = 32'h7FFF_FFFF;
        8: v = 32'h8000_0000;
        15: v = '1;
        default: v = c * 32'h1111_1111;
      endcase
      script.push_back(item_step(v, c == MAX_ROW_DEF - 1, 0, '0, '0));
    end
    // zero length acts as flat mode; a repeat extends the run
    script.push_back(cfg_step('0, 1'b0, 1'b1));
    script.push_back(item_step(32'd5, 1'b0, 0, '0, '0));
    script.push_back(item_step(32'd5, 1'b0, 0, '0, '0));
    script.push_back(item_step(32'd7, 1'b1, 0, '0, '0));
    // oversized length clamps; stream ends mid-row before any row completes
    script.push_back(cfg_step(5'd31, 1'b0, 1'b0));
    script.push_back(item_step(32'd1, 1'b0, 0, '0, '0));
    script.push_back(item_step(32'd2, 1'b1, 1, mk(KIND_END, 32'd1, '0, '0, 1'b1), '0));
    // shrink the row length mid-row
    script.push_back(cfg_step(5'd3, 1'b1, 1'b0));
    script.push_back(item_step(32'd9, 1'b0, 0, '0, '0));
    script.push_back(cfg_step(5'd1, 1'b1, 1'b0));
    script.push_back(item_step(32'd9, 1'b0, 0, '0, '0));
    script.push_back(item_step(32'd8, 1'b1, 0, '0, '0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      st = script[i];
      if (st.kind == STEP_CFG) begin
        settle();
        apply_config(st.cfg.row_length, st.cfg.want_inverse, st.cfg.want_counts);
      end else begin
        send_item(st.it, st.n_typed, st.t0, st.t1);
      end
    end

    total_items = 0;
    phase = 0;
    while (total_items < RANDOM_ITEMS) begin
      run_phase($urandom_range(15, 40), phase == 1);
      phase++;
    end

    push <= 1'b0;
    while (collapsed_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
